// ----- src/odo_pkg.sv -----
// ----------------------------------------------------------------------------
// odo_pkg
// Shared widths, constants, tables and control types of the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

    localparam int SPD_W  = 16;             // wheel speed
    localparam int POS_W  = 24;             // Q16.8 position
    localparam int ANG_W  = 16;             // binary angle
    localparam int WB_W   = 16;             // wheel base
    localparam int TS_W   = 12;             // time step
    localparam int CFG_W  = 24;             // widest register
    localparam int ADR_W  = 3;

    localparam int P_W    = 29;             // (l + r) * time_step, signed
    localparam int E_W    = 28;             // |r - l| * time_step
    localparam int PX_W   = 45;             // p * gain
    localparam int PE_W   = 50;             // e * rad-to-angle
    localparam int Q_W    = 35;             // divider dividend / quotient
    localparam int CX_W   = 31;             // rotator vector
    localparam int Z_W    = 18;             // rotator residual angle
    localparam int DEL_W  = 23;             // rounded position delta
    localparam int SUM_W  = 26;             // pose + delta

    localparam int CNT_W  = 6;
    localparam int MULA_N = TS_W;           // bits of the time step, first product
    localparam int MULB_N = 22;             // bits of the constant product
    localparam int ITER_N = Q_W;            // divider quotient bits (rotator overlaps)
    localparam int ROT_N  = 14;

    localparam logic [MULB_N-1:0] GAIN_K   = 22'd39797;    // rotator gain, Q0.16
    localparam logic [MULB_N-1:0] RAD2BAM_K = 22'd2670176; // 256/(2 pi), Q.16

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

    localparam logic [ADR_W-1:0] REG_WHEEL_BASE = 3'd0;
    localparam logic [ADR_W-1:0] REG_TIME_STEP  = 3'd1;
    localparam logic [ADR_W-1:0] REG_START_X    = 3'd2;
    localparam logic [ADR_W-1:0] REG_START_Y    = 3'd3;
    localparam logic [ADR_W-1:0] REG_START_HEAD = 3'd4;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [3:0] iter;
    } rot_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    function automatic logic [13:0] atan_bam(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/odo_rot.sv -----
// ----------------------------------------------------------------------------
// odo_rot
// Iterative rotator: one shift-add step per cycle while step is asserted turns (x0, 0) by the heading.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_rot
    import odo_pkg::*;
(
    input  wire logic                   clk,
    input  wire rot_ctl_t               ctl,
    input  wire logic signed [P_W-1:0]  x0,
    input  wire logic [ANG_W-1:0]       ang,
    output logic signed [CX_W-1:0]      cx,
    output logic signed [CX_W-1:0]      cy
);

    logic signed [CX_W-1:0] x_reg, x_next;
    logic signed [CX_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic signed [CX_W-1:0] x0_ext, sx, sy;
    logic signed [Z_W-1:0]  z0, at;

    always_comb
    begin
        x0_ext = CX_W'(x0);
        z0     = Z_W'(signed'(ang));
        sx     = x_reg >>> ctl.iter;
        sy     = y_reg >>> ctl.iter;
        at     = Z_W'(atan_bam(ctl.iter));
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctl.load)
        begin
            y_next = '0;
            // fold the back half-plane onto the front one
            if (z0 > Z_W'(16384))
            begin
                x_next = -x0_ext;
                z_next = z0 - Z_W'(32768);
            end
            else if (z0 < -Z_W'(16384))
            begin
                x_next = -x0_ext;
                z_next = z0 + Z_W'(32768);
            end
            else
            begin
                x_next = x0_ext;
                z_next = z0;
            end
        end
        else if (ctl.step)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign cx = x_reg;
    assign cy = y_reg;

endmodule

`default_nettype wire

// ----- src/odo_div.sv -----
// ----------------------------------------------------------------------------
// odo_div
// Bit-serial restoring divider, one quotient bit per cycle while step is asserted, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_div
    import odo_pkg::*;
(
    input  wire logic              clk,
    input  wire div_ctl_t          ctl,
    input  wire logic [Q_W-1:0]    dividend,
    input  wire logic [WB_W-1:0]   divisor,
    output logic [Q_W-1:0]         quot
);

    logic [WB_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]  dq_reg, dq_next;
    logic [WB_W-1:0] dv_reg, dv_next;
    logic [WB_W:0]   trial, diff;
    logic            ge;

    always_comb
    begin
        trial    = {rem_reg, dq_reg[Q_W-1]};
        ge       = trial >= {1'b0, dv_reg};
        diff     = trial - {1'b0, dv_reg};
        rem_next = rem_reg;
        dq_next  = dq_reg;
        dv_next  = dv_reg;
        if (ctl.load)
        begin
            rem_next = '0;
            dq_next  = dividend;
            dv_next  = divisor;
        end
        else if (ctl.step)
        begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            rem_next = ge ? diff[WB_W-1:0] : trial[WB_W-1:0];
            dq_next  = {dq_reg[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dv_reg  <= dv_next;
    end

    assign quot = dq_reg;

endmodule

`default_nettype wire

// ----- src/differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Fixed-point dead reckoning: emits the pose, then steps it by the wheel speeds.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                           | payload
//  s_axis   | in  | tvalid tready tdata[39:0]         | left_speed, right_speed, restart
//  m_axis   | out | tvalid tready tdata[71:0]         | pos_x, pos_y, heading, saturated
//  cfg      | in  | cfg_we cfg_addr[2:0] cfg_wdata    | register writes, no read-back
//
//  One tick runs from transfer to result through the bit-serial time-step
//  product, the bit-serial constant products and the restoring divider
//  (the 14 rotator steps run beside it), then a finish state. The next
//  transfer is taken only back in idle, after the finish state.
//  The divider sets the length. Reset loads the start pose at once.
//  A stalled result holds the block in its finish state; the next item is
//  taken once the result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry
    import odo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [39:0]        s_axis_tdata,   // left_speed, right_speed, restart
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [71:0]             m_axis_tdata,   // pos_x, pos_y, heading, saturated
    input  wire logic               cfg_we,
    input  wire logic [ADR_W-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULA = 3'd1;
    localparam logic [2:0] ST_MULB = 3'd2;
    localparam logic [2:0] ST_ITER = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [WB_W-1:0]          wb_reg;
    logic [TS_W-1:0]          ts_reg;
    logic signed [POS_W-1:0]  sx_reg, sy_reg;
    logic [ANG_W-1:0]         sh_reg;
    logic signed [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic [ANG_W-1:0]         ph_reg, ph_next;

    logic                     ov_reg, ov_next;
    logic [71:0]              od_reg, od_next;

    logic signed [P_W-1:0]    msa_reg, msa_next, pacc_reg, pacc_next;
    logic [E_W-1:0]           mea_reg, mea_next, eacc_reg, eacc_next;
    logic [TS_W-1:0]          tsb_reg, tsb_next;
    logic                     dneg_reg, dneg_next;
    logic signed [PX_W-1:0]   pmx_reg, pmx_next, prx_reg, prx_next;
    logic [PE_W-1:0]          pme_reg, pme_next, pre_reg, pre_next;

    logic signed [SPD_W-1:0]  lsp, rsp;
    logic signed [SPD_W:0]    ssum, sdif;
    logic                     accept, fin_go;
    logic [WB_W-1:0]          wbe;
    logic [PE_W:0]            nsum;

    rot_ctl_t                 rctl;
    div_ctl_t                 dctl;
    logic signed [CX_W-1:0]   cx, cy;
    logic [Q_W-1:0]           quot;

    logic signed [CX_W:0]     rx, ry;
    logic signed [DEL_W-1:0]  dx, dy;
    logic signed [SUM_W-1:0]  tx, ty;
    logic signed [POS_W-1:0]  nx, ny;
    logic                     clip;

    assign lsp    = s_axis_tdata[15:0];
    assign rsp    = s_axis_tdata[31:16];
    assign ssum   = (SPD_W+1)'(lsp) + (SPD_W+1)'(rsp);
    assign sdif   = (SPD_W+1)'(rsp) - (SPD_W+1)'(lsp);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign fin_go = (state_reg == ST_FIN) && (!ov_reg || m_axis_tready);
    assign wbe    = (wb_reg == '0) ? WB_W'(1) : wb_reg;
    // (m + wb * 2^15) / 2^16 then / wb gives the rounded quotient;
    // the accumulator starts at wb * 2^15 and its last partial product
    // goes straight into the divider load
    assign nsum   = {1'b0, pre_next};

    always_comb
    begin
        rctl.load = (state_reg == ST_MULB) && (cnt_reg == CNT_W'(MULB_N-1));
        rctl.step = (state_reg == ST_ITER) && (cnt_reg < CNT_W'(ROT_N));
        rctl.iter = cnt_reg[3:0];
        dctl.load = rctl.load;
        dctl.step = (state_reg == ST_ITER);
    end

    odo_rot u_rot
    (
        .clk (clk),
        .ctl (rctl),
        .x0  (prx_reg[PX_W-1:16]),
        .ang (ph_reg),
        .cx  (cx),
        .cy  (cy)
    );

    odo_div u_div
    (
        .clk      (clk),
        .ctl      (dctl),
        .dividend (nsum[PE_W:16]),
        .divisor  (wbe),
        .quot     (quot)
    );

    // round to Q.8 half up and saturate
    always_comb
    begin
        rx   = (CX_W+1)'(cx) + (CX_W+1)'(256);
        ry   = (CX_W+1)'(cy) + (CX_W+1)'(256);
        dx   = DEL_W'(rx >>> 9);
        dy   = DEL_W'(ry >>> 9);
        tx   = SUM_W'(px_reg) + SUM_W'(dx);
        ty   = SUM_W'(py_reg) + SUM_W'(dy);
        clip = 1'b0;
        if (tx > SUM_W'(POS_MAX))
        begin
            nx = POS_MAX; clip = 1'b1;
        end
        else if (tx < SUM_W'(POS_MIN))
        begin
            nx = POS_MIN; clip = 1'b1;
        end
        else
        begin
            nx = tx[POS_W-1:0];
        end
        if (ty > SUM_W'(POS_MAX))
        begin
            ny = POS_MAX; clip = 1'b1;
        end
        else if (ty < SUM_W'(POS_MIN))
        begin
            ny = POS_MIN; clip = 1'b1;
        end
        else
        begin
            ny = ty[POS_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        ph_next    = ph_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        msa_next   = msa_reg;
        mea_next   = mea_reg;
        pacc_next  = pacc_reg;
        eacc_next  = eacc_reg;
        tsb_next   = tsb_reg;
        dneg_next  = dneg_reg;
        pmx_next   = pmx_reg;
        pme_next   = pme_reg;
        prx_next   = prx_reg;
        pre_next   = pre_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tdata[32])
                    begin
                        px_next = sx_reg;
                        py_next = sy_reg;
                        ph_next = sh_reg;
                    end
                    msa_next   = P_W'(ssum);
                    dneg_next  = sdif[SPD_W];
                    mea_next   = sdif[SPD_W] ? E_W'(-sdif) : E_W'(sdif);
                    tsb_next   = ts_reg;
                    pacc_next  = '0;
                    eacc_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_MULA;
                end
            end
            ST_MULA:
            begin
                if (tsb_reg[0])
                begin
                    pacc_next = pacc_reg + msa_reg;
                    eacc_next = eacc_reg + mea_reg;
                end
                msa_next = msa_reg <<< 1;
                mea_next = mea_reg << 1;
                tsb_next = tsb_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MULA_N-1))
                begin
                    pmx_next   = PX_W'(pacc_next);
                    pme_next   = PE_W'(eacc_next);
                    prx_next   = '0;
                    pre_next   = PE_W'(wbe) << 15;
                    cnt_next   = '0;
                    state_next = ST_MULB;
                end
            end
            ST_MULB:
            begin
                if (GAIN_K[cnt_reg[4:0]])
                begin
                    prx_next = prx_reg + pmx_reg;
                end
                if (RAD2BAM_K[cnt_reg[4:0]])
                begin
                    pre_next = pre_reg + pme_reg;
                end
                pmx_next = pmx_reg <<< 1;
                pme_next = pme_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MULB_N-1))
                begin
                    // last constant bit: rotator and divider load now
                    cnt_next   = '0;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ITER_N-1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    ov_next    = 1'b1;
                    od_next    = {7'd0, clip, ph_reg, py_reg, px_reg};
                    px_next    = nx;
                    py_next    = ny;
                    ph_next    = dneg_reg ? ph_reg - quot[ANG_W-1:0]
                                          : ph_reg + quot[ANG_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            wb_reg    <= 16'd7680;
            ts_reg    <= 12'd256;
            sx_reg    <= 24'sd7680;
            sy_reg    <= 24'sd7680;
            sh_reg    <= 16'd8192;
            px_reg    <= 24'sd7680;
            py_reg    <= 24'sd7680;
            ph_reg    <= 16'd8192;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            ph_reg    <= ph_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WHEEL_BASE: wb_reg <= cfg_wdata[WB_W-1:0];
                    REG_TIME_STEP:  ts_reg <= cfg_wdata[TS_W-1:0];
                    REG_START_X:    sx_reg <= cfg_wdata;
                    REG_START_Y:    sy_reg <= cfg_wdata;
                    REG_START_HEAD: sh_reg <= cfg_wdata[ANG_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg   <= od_next;
        msa_reg  <= msa_next;
        mea_reg  <= mea_next;
        pacc_reg <= pacc_next;
        eacc_reg <= eacc_next;
        tsb_reg  <= tsb_next;
        dneg_reg <= dneg_next;
        pmx_reg  <= pmx_next;
        pme_reg  <= pme_next;
        prx_reg  <= prx_next;
        pre_reg  <= pre_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MULA) && (cnt_reg == '0))
        else $error("transfer did not start the product phase");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish cycle");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (cnt_reg < CNT_W'(ITER_N)))
        else $error("divider ran past its length");

    a_fin_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (state_reg == ST_IDLE) && m_axis_tvalid)
        else $error("finish did not hand over a result");

endmodule

`default_nettype wire
